>>> rtl/lsgp_pkg.sv
// Package for the line segment grid point rasterizer.
// Holds the coordinate widths, the queue geometry and the structs passed
// between the front, the queue and the back. No dependencies.
package lsgp_pkg;

  // Grid geometry
  localparam int GRID_SIZE = 64;
  localparam int COORD_W   = 6;
  localparam logic [COORD_W-1:0] GRID_MAX = COORD_W'(GRID_SIZE - 1);

  // Signed difference of two coordinates, and the remainder range [0, 2n)
  localparam int DIFF_W = COORD_W + 1;
  localparam int REM_W  = COORD_W + 1;
  localparam int SUM_W  = REM_W + 2;

  // Segment queue between front and back
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Input tdata layout, lowest bit up
  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 16;

  // One classified segment, ready for stepping
  typedef struct packed {
    logic                      x_major;     // step along x
    logic                      major_neg;   // major axis runs downward
    logic [COORD_W-1:0]        major_start;
    logic [COORD_W-1:0]        minor_start;
    logic [COORD_W-1:0]        steps;       // n, always nonzero
    logic signed [DIFF_W-1:0]  minor_delta; // end minus start on minor axis
    logic                      with_start;
  } seg_desc_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Saturate a coordinate to the grid
  function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
    clamp_coord = (v > GRID_MAX) ? GRID_MAX : v;
  endfunction

endpackage

>>> rtl/lsgp_front.sv
// Front of the rasterizer: accepts a segment item, clamps its endpoints,
// picks the major axis and pushes a descriptor into the queue.
// Depends on lsgp_pkg.
module lsgp_front
  import lsgp_pkg::*;
(
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // x_start, y_start, x_end, y_end, include_start, include_end
  input  queue_status_t        q_status,
  output logic                 q_push,
  output seg_desc_t            q_desc
);

  logic [COORD_W-1:0]       x1, y1, x2, y2;
  logic signed [DIFF_W-1:0] dx, dy;
  logic [COORD_W-1:0]       adx, ady;
  logic                     x_major;

  // Unpack and clamp the endpoints
  assign x1 = clamp_coord(s_tdata[COORD_W-1:0]);
  assign y1 = clamp_coord(s_tdata[2*COORD_W-1:COORD_W]);
  assign x2 = clamp_coord(s_tdata[3*COORD_W-1:2*COORD_W]);
  assign y2 = clamp_coord(s_tdata[4*COORD_W-1:3*COORD_W]);

  // Deltas and their magnitudes
  assign dx  = $signed({1'b0, x2}) - $signed({1'b0, x1});
  assign dy  = $signed({1'b0, y2}) - $signed({1'b0, y1});
  assign adx = dx[DIFF_W-1] ? COORD_W'(-dx) : dx[COORD_W-1:0];
  assign ady = dy[DIFF_W-1] ? COORD_W'(-dy) : dy[COORD_W-1:0];

  // Ties between the axes step along x
  assign x_major = (ady <= adx);

  always_comb begin
    q_desc.x_major     = x_major;
    q_desc.major_neg   = x_major ? dx[DIFF_W-1] : dy[DIFF_W-1];
    q_desc.major_start = x_major ? x1 : y1;
    q_desc.minor_start = x_major ? y1 : x1;
    q_desc.steps       = x_major ? adx : ady;
    q_desc.minor_delta = x_major ? dy : dx;
    q_desc.with_start  = s_tdata[4*COORD_W];
  end

  // Zero-length segments are taken and dropped
  assign s_tready = !q_status.full;
  assign q_push   = s_tvalid && s_tready && (q_desc.steps != '0);

endmodule

>>> rtl/lsgp_queue.sv
// Short register queue of segment descriptors between front and back.
// Depends on lsgp_pkg.
module lsgp_queue
  import lsgp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  seg_desc_t     din,
  input  logic          pop,
  output seg_desc_t     dout,
  output queue_status_t status
);

  seg_desc_t         slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push, do_pop;

  assign status.full  = (count == QCNT_W'(QDEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign dout         = slots[rd_ptr];

  // Payload slots
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/lsgp_back.sv
// Back of the rasterizer: takes one descriptor at a time and walks the
// major axis, keeping the rounded minor coordinate with a remainder.
// Depends on lsgp_pkg.
module lsgp_back
  import lsgp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  seg_desc_t            q_desc,
  input  queue_status_t        q_status,
  output logic                 q_pop,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // point_x, point_y, zero fill
  output logic                 m_tlast
);

  typedef enum logic {IDLE, RUN} state_t;

  state_t             state;
  seg_desc_t          seg;
  logic [COORD_W-1:0] major, minor, step_idx;
  logic [REM_W-1:0]   rem;
  logic [COORD_W-1:0] out_x, out_y;

  logic                    advance, emit, at_end;
  logic signed [SUM_W-1:0] rem_sum, two_n;
  logic [REM_W-1:0]        rem_next;
  logic [COORD_W-1:0]      minor_next, major_next;

  // Output register moves when empty or taken
  assign advance = !m_tvalid || m_tready;
  assign q_pop   = (state == IDLE) && !q_status.empty;
  assign emit    = (step_idx != '0) || seg.with_start;
  assign at_end  = (step_idx == seg.steps);

  // Remainder update: add 2*dm, fold back once into [0, 2n)
  always_comb begin
    two_n      = $signed({2'b00, seg.steps, 1'b0});
    rem_sum    = $signed({2'b00, rem}) +
                 $signed({seg.minor_delta[DIFF_W-1], seg.minor_delta, 1'b0});
    rem_next   = rem_sum[REM_W-1:0];
    minor_next = minor;
    if (rem_sum >= two_n) begin
      rem_next   = REM_W'(rem_sum - two_n);
      minor_next = minor + 1'b1;
    end else if (rem_sum < 0) begin
      rem_next   = REM_W'(rem_sum + two_n);
      minor_next = minor - 1'b1;
    end
    major_next = seg.major_neg ? major - 1'b1 : major + 1'b1;
  end

  // Stepping state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (advance) begin
        m_tvalid <= (state == RUN) && emit;
      end
      case (state)
        IDLE: begin
          if (q_pop) begin
            seg      <= q_desc;
            major    <= q_desc.major_start;
            minor    <= q_desc.minor_start;
            rem      <= REM_W'(q_desc.steps);
            step_idx <= '0;
            state    <= RUN;
          end
        end
        RUN: begin
          if (advance) begin
            if (emit) begin
              out_x   <= seg.x_major ? major : minor;
              out_y   <= seg.x_major ? minor : major;
              m_tlast <= at_end;
            end
            if (at_end) begin
              state <= IDLE;
            end else begin
              step_idx <= step_idx + 1'b1;
              major    <= major_next;
              minor    <= minor_next;
              rem      <= rem_next;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign m_tdata = {{(M_TDATA_W - 2*COORD_W){1'b0}}, out_y, out_x};

endmodule

>>> rtl/line_segment_grid_points.sv
// Top level of the line segment grid point rasterizer (DDA, exact rounding).
// Connects lsgp_front, lsgp_queue and lsgp_back. Depends on lsgp_pkg.
//
//   channel  dir  handshake            payload
//   s_*      in   s_tvalid / s_tready  tdata: x_start, y_start, x_end, y_end,
//                                      include_start, include_end
//   m_*      out  m_tvalid / m_tready  tdata: point_x, point_y; tlast: last_point
//
// A segment of n major-axis steps occupies the stepping unit for a load
// and then one step per step index 0..n; an excluded start point still
// spends its step. The front takes a new segment every cycle while the
// two-entry queue has room; zero-length segments are taken and produce no
// points. Synchronous reset empties the queue and the output register. A
// stalled output holds the stepper.
module line_segment_grid_points
  import lsgp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // x_start, y_start, x_end, y_end, include_start, include_end
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // point_x, point_y, zero fill
  output logic                 m_tlast
);

  queue_status_t q_status;
  seg_desc_t     push_desc, pop_desc;
  logic          q_push, q_pop;

  lsgp_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_status (q_status),
    .q_push   (q_push),
    .q_desc   (push_desc)
  );

  lsgp_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .din    (push_desc),
    .pop    (q_pop),
    .dout   (pop_desc),
    .status (q_status)
  );

  lsgp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_desc   (pop_desc),
    .q_status (q_status),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // Never push into a full queue, nor pop an empty one
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_status.full)
    else $error("segment pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_status.empty)
    else $error("segment popped from empty queue");

  // Queue cannot be both full and empty
  a_status_sane: assert property (@(posedge clk) disable iff (rst)
    !(q_status.full && q_status.empty))
    else $error("queue status inconsistent");

  // Reset leaves no point pending and the input open
  a_reset_clear: assert property (@(posedge clk)
    rst |=> (!m_tvalid && s_tready))
    else $error("output or queue not cleared by reset");

endmodule

>>> sim/tb_top.sv
// Testbench for line_segment_grid_points: drives segments, rasterizes them
// in a local model and checks every emitted grid point and its last flag.
// Depends on lsgp_pkg and the RTL top level.
module tb_top;
  import lsgp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_PER_PHASE = 130;
  localparam int DRAIN_CYCLES     = 150;

  // One grid point as it leaves the block
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               last;
  } grid_point_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;  // x_start, y_start, x_end, y_end, include_start, include_end
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;       // point_x, point_y, zero fill
  logic                 m_tlast;

  logic [S_TDATA_W-1:0] segments_to_send[$];
  grid_point_t          pending_points[$];
  logic                 seg_taken = 1'b0;
  int                   send_idle_pct = 0;
  int                   recv_idle_pct = 0;
  int                   mismatches = 0;

  line_segment_grid_points dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatches++;
  endtask

  function automatic logic [S_TDATA_W-1:0] pack_segment(input int xs, input int ys,
                                                        input int xe, input int ye,
                                                        input bit with_start,
                                                        input bit with_end);
    logic [S_TDATA_W-1:0] d;
    d = '0;
    d[5:0]   = COORD_W'(xs);
    d[11:6]  = COORD_W'(ys);
    d[17:12] = COORD_W'(xe);
    d[23:18] = COORD_W'(ye);
    d[24]    = with_start;
    d[25]    = with_end;
    return d;
  endfunction

  // Walk the major axis and queue every point to be emitted, minor axis rounded half up
  function automatic void rasterize_segment(input logic [S_TDATA_W-1:0] d);
    int          xs, ys, xe, ye, dx, dy, adx, ady;
    int          n, dir, i, maj0, min0, dmin, num, major, minor;
    bit          x_major;
    grid_point_t p;
    xs = int'(d[5:0]);
    ys = int'(d[11:6]);
    xe = int'(d[17:12]);
    ye = int'(d[23:18]);
    dx = xe - xs;
    dy = ye - ys;
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    x_major = (ady <= adx);
    n    = x_major ? adx : ady;
    dir  = x_major ? ((dx < 0) ? -1 : 1) : ((dy < 0) ? -1 : 1);
    maj0 = x_major ? xs : ys;
    min0 = x_major ? ys : xs;
    dmin = x_major ? dy : dx;
    if (n == 0) return;
    for (i = d[24] ? 0 : 1; i <= n; i++) begin
      major = maj0 + dir * i;
      num   = 2 * (min0 * n + dmin * i) + n;
      minor = num / (2 * n);
      p.x    = x_major ? COORD_W'(major) : COORD_W'(minor);
      p.y    = x_major ? COORD_W'(minor) : COORD_W'(major);
      p.last = (i == n);
      pending_points.push_back(p);
    end
  endfunction

  // Mostly short segments, some across the whole grid, a few of zero length
  function automatic logic [S_TDATA_W-1:0] random_segment();
    int xs, ys, xe, ye, kind;
    kind = $urandom_range(9);
    xs = $urandom_range(GRID_SIZE - 1);
    ys = $urandom_range(GRID_SIZE - 1);
    if (kind == 0) begin
      xe = xs;
      ye = ys;
    end else if (kind <= 5) begin
      xe = $urandom_range((xs + 5 > 63) ? 63 : xs + 5, (xs < 5) ? 0 : xs - 5);
      ye = $urandom_range((ys + 5 > 63) ? 63 : ys + 5, (ys < 5) ? 0 : ys - 5);
    end else begin
      xe = $urandom_range(GRID_SIZE - 1);
      ye = $urandom_range(GRID_SIZE - 1);
    end
    return pack_segment(xs, ys, xe, ye, 1'($urandom_range(1)), 1'($urandom_range(1)));
  endfunction

  // Sender: keep the item until taken, then maybe idle before the next one
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || seg_taken) begin
      if (segments_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata  <= segments_to_send.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Input acceptance feeds the model; output acceptance is checked
  always @(posedge clk) begin
    grid_point_t want;
    seg_taken <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) rasterize_segment(s_tdata);
    if (!rst && m_tvalid && m_tready) begin
      if (pending_points.size() == 0) begin
        report_mismatch($sformatf("unexpected point (%0d,%0d) last=%0b",
                                  m_tdata[5:0], m_tdata[11:6], m_tlast));
      end else begin
        want = pending_points.pop_front();
        if (m_tdata[5:0] !== want.x)
          report_mismatch($sformatf("point_x %0d, want %0d", m_tdata[5:0], want.x));
        if (m_tdata[11:6] !== want.y)
          report_mismatch($sformatf("point_y %0d, want %0d", m_tdata[11:6], want.y));
        if (m_tlast !== want.last)
          report_mismatch($sformatf("last_point %0b, want %0b", m_tlast, want.last));
      end
    end
  end

  // Stimulus in three phases of differing idle rates, the last with none, then drain
  initial begin
    int phase, k;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 54 : 0;
      recv_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 25 : 0;
      if (phase == 0) begin
        // zero length, axis aligned, diagonals, extremes, rounding ties
        segments_to_send.push_back(pack_segment(10, 20, 10, 20, 1, 1));
        segments_to_send.push_back(pack_segment(0, 0, 0, 0, 0, 0));
        segments_to_send.push_back(pack_segment(0, 0, 63, 0, 1, 0));
        segments_to_send.push_back(pack_segment(63, 5, 0, 5, 0, 1));
        segments_to_send.push_back(pack_segment(7, 0, 7, 63, 1, 1));
        segments_to_send.push_back(pack_segment(7, 63, 7, 0, 0, 0));
        segments_to_send.push_back(pack_segment(0, 0, 63, 63, 1, 1));
        segments_to_send.push_back(pack_segment(63, 0, 0, 63, 0, 0));
        segments_to_send.push_back(pack_segment(63, 63, 0, 0, 1, 0));
        segments_to_send.push_back(pack_segment(0, 63, 63, 0, 1, 1));
        segments_to_send.push_back(pack_segment(0, 0, 63, 1, 1, 0));
        segments_to_send.push_back(pack_segment(0, 63, 1, 0, 1, 1));
        segments_to_send.push_back(pack_segment(0, 0, 2, 1, 1, 0));
        segments_to_send.push_back(pack_segment(0, 1, 2, 0, 1, 1));
        segments_to_send.push_back(pack_segment(2, 0, 0, 1, 1, 0));
        segments_to_send.push_back(pack_segment(1, 0, 0, 2, 1, 1));
        segments_to_send.push_back(pack_segment(5, 5, 6, 5, 0, 0));
        segments_to_send.push_back(pack_segment(63, 63, 62, 62, 0, 1));
        segments_to_send.push_back(pack_segment(10, 40, 50, 3, 1, 1));
        segments_to_send.push_back(pack_segment(33, 12, 40, 61, 0, 0));
      end
      for (k = 0; k < RANDOM_PER_PHASE; k++)
        segments_to_send.push_back(random_segment());
      while (segments_to_send.size() != 0 || s_tvalid) @(posedge clk);
    end
    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Hard stop if the flow hangs
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
